### design/mcfd_pkg.sv
`timescale 1ns / 1ps

package mcfd_pkg;

    localparam int GRID_SIZE = 64;
    localparam int IN_W      = 6;
    localparam int ROW_W     = $clog2(GRID_SIZE);
    // signed circle coordinate: center plus or minus radius, with room for GRID_SIZE 256
    localparam int COORD_W   = 10;
    localparam int D_W       = 12;

    localparam logic CMD_DRAW = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DRAW,
        ST_DRAIN,
        ST_RD_DATA
    } state_t;

    // one row group: two symmetric points that share a framebuffer row
    typedef struct packed {
        logic   valid;
        logic   last;
        coord_t row;
        coord_t col_a;
        coord_t col_b;
    } grp_t;

    function automatic coord_t widen(logic [IN_W-1:0] v);
        return coord_t'({{(COORD_W-IN_W){1'b0}}, v});
    endfunction

    function automatic logic coord_ok(coord_t c);
        return !c[COORD_W-1] && (c[COORD_W-2:0] < (COORD_W-1)'(GRID_SIZE));
    endfunction

endpackage

### design/mcfd_req_if.sv
`timescale 1ns / 1ps

interface mcfd_req_if;
    import mcfd_pkg::*;

    logic            valid;
    logic            ready;
    logic            cmd;
    logic [IN_W-1:0] row;
    logic [IN_W-1:0] col;
    logic [IN_W-1:0] radius;
    logic            pen;

    modport source (output valid, cmd, row, col, radius, pen, input ready);
    modport sink   (input valid, cmd, row, col, radius, pen, output ready);

endinterface

### design/mcfd_rsp_if.sv
`timescale 1ns / 1ps

interface mcfd_rsp_if;
    logic valid;
    logic ready;
    logic pixel_bit;
    logic clipped;

    modport source (output valid, pixel_bit, clipped, input ready);
    modport sink   (input valid, pixel_bit, clipped, output ready);

endinterface

### design/mcfd_fb_ram.sv
`timescale 1ns / 1ps

module mcfd_fb_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### design/mcfd_octant_step.sv
`timescale 1ns / 1ps

module mcfd_octant_step (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [mcfd_pkg::IN_W-1:0] row,
    input  logic [mcfd_pkg::IN_W-1:0] col,
    input  logic [mcfd_pkg::IN_W-1:0] radius,
    output mcfd_pkg::grp_t           grp
);
    import mcfd_pkg::*;

    logic                  active_reg, active_next;
    logic [1:0]            sel_reg, sel_next;
    logic [IN_W-1:0]       x_reg, x_next;
    logic [IN_W-1:0]       y_reg, y_next;
    logic signed [D_W-1:0] d_reg, d_next;
    logic [IN_W-1:0]       cr_reg, cr_next;
    logic [IN_W-1:0]       cc_reg, cc_next;

    logic [IN_W-1:0]       a_val;
    logic [IN_W-1:0]       b_val;
    logic                  more;
    logic [IN_W-1:0]       x_inc;
    logic [IN_W-1:0]       y_dec;

    // groups 0,1 use row center +/- x, groups 2,3 row center +/- y
    assign a_val = sel_reg[1] ? y_reg : x_reg;
    assign b_val = sel_reg[1] ? x_reg : y_reg;
    assign more  = x_reg < y_reg;
    assign x_inc = x_reg + 1'b1;
    assign y_dec = y_reg - 1'b1;

    always_comb
    begin
        grp.valid = active_reg;
        grp.last  = active_reg && (sel_reg == 2'd3) && !more;
        grp.row   = sel_reg[0] ? (widen(cr_reg) - widen(a_val))
                               : (widen(cr_reg) + widen(a_val));
        grp.col_a = widen(cc_reg) + widen(b_val);
        grp.col_b = widen(cc_reg) - widen(b_val);
    end

    always_comb
    begin
        active_next = active_reg;
        sel_next    = sel_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        d_next      = d_reg;
        cr_next     = cr_reg;
        cc_next     = cc_reg;
        if (start)
        begin
            active_next = 1'b1;
            sel_next    = 2'd0;
            x_next      = '0;
            y_next      = radius;
            d_next      = D_W'(1) - D_W'(radius);
            cr_next     = row;
            cc_next     = col;
        end
        else if (active_reg)
        begin
            sel_next = sel_reg + 2'd1;
            if (sel_reg == 2'd3)
            begin
                if (more)
                begin
                    x_next = x_inc;
                    if (d_reg < 0)
                    begin
                        d_next = d_reg + D_W'({x_inc, 1'b1});
                    end
                    else
                    begin
                        y_next = y_dec;
                        d_next = d_reg + ((D_W'(x_inc) - D_W'(y_dec)) <<< 1) + D_W'(1);
                    end
                end
                else
                begin
                    active_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            sel_reg    <= 2'd0;
        end
        else
        begin
            active_reg <= active_next;
            sel_reg    <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg  <= x_next;
        y_reg  <= y_next;
        d_reg  <= d_next;
        cr_reg <= cr_next;
        cc_reg <= cc_next;
    end

endmodule

### design/midpoint_circle_framebuffer_draw.sv
`timescale 1ns / 1ps

// Draws midpoint circles into a 64x64 one-bit framebuffer held as one row of 64 bits
// per memory word, and reads single pixels back. After reset the block sweeps the
// memory to zero, one row a cycle, before it takes its first item.
// A draw walks one octant; each octant step is four row groups (two points per
// row), and each group is a read-modify-write of one row issued at one group per
// cycle, with the written row forwarded when the next group hits the same row.
// Points off the grid are skipped and the draw result reports clipped = 1.
module midpoint_circle_framebuffer_draw (
    input  logic       clk,
    input  logic       rst_n,
    mcfd_req_if.sink   req,
    mcfd_rsp_if.source rsp
);
    import mcfd_pkg::*;

    state_t             state_reg, state_next;
    logic [ROW_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic               clip_reg, clip_next;
    logic               pen_reg;
    logic [ROW_W-1:0]   col_reg;
    logic               rd_ok_reg;
    logic               rsp_valid_reg, rsp_valid_next;
    logic               pix_reg, pix_next;
    logic               clip_out_reg, clip_out_next;

    logic               s2_valid_reg;
    logic               s2_fwd_reg;
    logic [ROW_W-1:0]   s2_row_reg;
    logic               s2_ca_ok_reg, s2_cb_ok_reg;
    logic [ROW_W-1:0]   s2_ca_reg, s2_cb_reg;
    logic [GRID_SIZE-1:0] wlast_reg;

    grp_t               grp;
    logic               accept;
    logic               start;
    logic               can_load;
    logic               load;
    logic               g_row_ok, g_ca_ok, g_cb_ok;
    coord_t             req_row_c, req_col_c;

    logic               rd_en;
    logic [ROW_W-1:0]   rd_addr;
    logic [GRID_SIZE-1:0] rd_data;
    logic               wr_en;
    logic [ROW_W-1:0]   wr_addr;
    logic [GRID_SIZE-1:0] wr_data;
    logic [GRID_SIZE-1:0] base_row;
    logic [GRID_SIZE-1:0] mod_row;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign start     = accept && (req.cmd == CMD_DRAW);
    assign can_load  = !rsp_valid_reg || rsp.ready;
    assign req_row_c = widen(req.row);
    assign req_col_c = widen(req.col);

    mcfd_octant_step u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .row    (req.row),
        .col    (req.col),
        .radius (req.radius),
        .grp    (grp)
    );

    // stage 1: issue the row read for the current group, or for an accepted read command
    assign g_row_ok = coord_ok(grp.row);
    assign g_ca_ok  = coord_ok(grp.col_a);
    assign g_cb_ok  = coord_ok(grp.col_b);

    always_comb
    begin
        if (grp.valid)
        begin
            rd_en   = g_row_ok;
            rd_addr = grp.row[ROW_W-1:0];
        end
        else
        begin
            rd_en   = accept && (req.cmd == CMD_READ);
            rd_addr = req_row_c[ROW_W-1:0];
        end
    end

    // stage 2: modify the row, taking the previous write when it hit the same row
    assign base_row = s2_fwd_reg ? wlast_reg : rd_data;

    always_comb
    begin
        mod_row = base_row;
        if (s2_ca_ok_reg)
        begin
            mod_row[s2_ca_reg] = pen_reg;
        end
        if (s2_cb_ok_reg)
        begin
            mod_row[s2_cb_reg] = pen_reg;
        end
    end

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = s2_valid_reg;
            wr_addr = s2_row_reg;
            wr_data = mod_row;
        end
    end

    mcfd_fb_ram #(
        .DEPTH (GRID_SIZE),
        .WIDTH (GRID_SIZE),
        .AW    (ROW_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        clip_next      = clip_reg;
        load           = 1'b0;
        pix_next       = pix_reg;
        clip_out_next  = clip_out_reg;
        if (grp.valid && !(g_row_ok && g_ca_ok && g_cb_ok))
        begin
            clip_next = 1'b1;
        end
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ROW_W'(GRID_SIZE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                clip_next = 1'b0;
                if (accept)
                begin
                    state_next = (req.cmd == CMD_DRAW) ? ST_DRAW : ST_RD_DATA;
                end
            end
            ST_DRAW:
            begin
                if (grp.last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (can_load)
                begin
                    load          = 1'b1;
                    pix_next      = 1'b0;
                    clip_out_next = clip_reg;
                    state_next    = ST_IDLE;
                end
            end
            ST_RD_DATA:
            begin
                if (can_load)
                begin
                    load          = 1'b1;
                    pix_next      = rd_ok_reg && rd_data[col_reg];
                    clip_out_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && !rsp.ready;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.pixel_bit = pix_reg;
    assign rsp.clipped   = clip_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            clip_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s2_fwd_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clip_reg      <= clip_next;
            rsp_valid_reg <= rsp_valid_next;
            s2_valid_reg  <= grp.valid && g_row_ok;
            s2_fwd_reg    <= grp.valid && g_row_ok && s2_valid_reg
                             && (s2_row_reg == grp.row[ROW_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg      <= pix_next;
        clip_out_reg <= clip_out_next;
        s2_row_reg   <= grp.row[ROW_W-1:0];
        s2_ca_ok_reg <= g_ca_ok;
        s2_cb_ok_reg <= g_cb_ok;
        s2_ca_reg    <= grp.col_a[ROW_W-1:0];
        s2_cb_reg    <= grp.col_b[ROW_W-1:0];
        wlast_reg    <= mod_row;
        if (accept)
        begin
            pen_reg   <= req.pen;
            col_reg   <= req_col_c[ROW_W-1:0];
            rd_ok_reg <= coord_ok(req_row_c) && coord_ok(req_col_c);
        end
    end

    // octant groups only come out while a draw is running
    assert property (@(posedge clk) disable iff (!rst_n)
        grp.valid |-> state_reg == ST_DRAW)
    else $error("row group issued outside a draw");

    // a forwarded row must come from a write to that row in the previous cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_fwd_reg && s2_valid_reg) |-> ($past(wr_en) && $past(wr_addr) == s2_row_reg))
    else $error("forwarding without a matching write");

    // the clearing pass runs once after reset
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_CLEAR |=> state_reg != ST_CLEAR)
    else $error("clearing pass restarted");

    // no row write may be pending when a draw result is loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN && load) |=> !s2_valid_reg)
    else $error("draw result loaded before its last write");

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import mcfd_pkg::*;

    localparam int ITEM_COUNT   = 2000;
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int TAIL_CYCLES  = 200;

    typedef struct packed {
        logic pixel_bit;
        logic clipped;
    } pix_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    mcfd_req_if req_if ();
    mcfd_rsp_if rsp_if ();

    midpoint_circle_framebuffer_draw i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // shadow of the framebuffer and the results still owed by the block
    logic     pix_mem [GRID_SIZE][GRID_SIZE];
    pix_rsp_t pending_pix_q [$];

    int fail_cnt  = 0;
    int cycle_cnt = 0;
    int burst_left = 0;

    // last circle drawn, so reads can land on its points
    logic [IN_W-1:0] last_row = '0;
    logic [IN_W-1:0] last_col = '0;
    logic [IN_W-1:0] last_rad = '0;

    function automatic logic set_pixel(int r, int c, logic pen);
        if (r < 0 || c < 0 || r >= GRID_SIZE || c >= GRID_SIZE)
            return 1'b1;
        pix_mem[r][c] = pen;
        return 1'b0;
    endfunction

    function automatic logic set_octants(int cr, int cc, int x, int y, logic pen);
        logic lost;
        lost  = set_pixel(cr + x, cc + y, pen);
        lost |= set_pixel(cr + x, cc - y, pen);
        lost |= set_pixel(cr - x, cc + y, pen);
        lost |= set_pixel(cr - x, cc - y, pen);
        lost |= set_pixel(cr + y, cc + x, pen);
        lost |= set_pixel(cr + y, cc - x, pen);
        lost |= set_pixel(cr - y, cc + x, pen);
        lost |= set_pixel(cr - y, cc - x, pen);
        return lost;
    endfunction

    // midpoint decision walk over one octant, returns 1 if any point fell off the grid
    function automatic logic paint_circle(int cr, int cc, int rad, logic pen);
        int   x;
        int   y;
        int   d;
        logic lost;
        x    = 0;
        y    = rad;
        d    = 1 - rad;
        lost = set_octants(cr, cc, x, y, pen);
        while (x < y)
        begin
            x++;
            if (d < 0)
            begin
                d = d + 2 * x + 1;
            end
            else
            begin
                y--;
                d = d + 2 * (x - y) + 1;
            end
            lost |= set_octants(cr, cc, x, y, pen);
        end
        return lost;
    endfunction

    task automatic send_cmd(logic cmd, logic [IN_W-1:0] row, logic [IN_W-1:0] col,
                            logic [IN_W-1:0] rad, logic pen);
        int       gap;
        pix_rsp_t exp_rsp;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 12);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 24);
        end
        burst_left--;
        req_if.valid  <= 1'b1;
        req_if.cmd    <= cmd;
        req_if.row    <= row;
        req_if.col    <= col;
        req_if.radius <= rad;
        req_if.pen    <= pen;
        do
            @(posedge clk);
        while (!req_if.ready);
        if (cmd == CMD_DRAW)
        begin
            exp_rsp.pixel_bit = 1'b0;
            exp_rsp.clipped   = paint_circle(int'(row), int'(col), int'(rad), pen);
            last_row = row;
            last_col = col;
            last_rad = rad;
        end
        else
        begin
            exp_rsp.pixel_bit = (int'(row) < GRID_SIZE && int'(col) < GRID_SIZE)
                                ? pix_mem[row][col] : 1'b0;
            exp_rsp.clipped   = 1'b0;
        end
        pending_pix_q.push_back(exp_rsp);
    endtask

    // hold the request side until every owed result is back
    task automatic wait_idle();
        req_if.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_pix_q.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        pix_rsp_t exp_rsp;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_pix_q.size() == 0)
            begin
                $error("result item with nothing pending: pixel_bit %0b clipped %0b",
                       rsp_if.pixel_bit, rsp_if.clipped);
                fail_cnt++;
            end
            else
            begin
                exp_rsp = pending_pix_q.pop_front();
                if (rsp_if.pixel_bit !== exp_rsp.pixel_bit)
                begin
                    $error("pixel_bit: expected %0b, actual %0b",
                           exp_rsp.pixel_bit, rsp_if.pixel_bit);
                    fail_cnt++;
                end
                if (rsp_if.clipped !== exp_rsp.clipped)
                begin
                    $error("clipped: expected %0b, actual %0b",
                           exp_rsp.clipped, rsp_if.clipped);
                    fail_cnt++;
                end
            end
        end
    end

    // receiver: runs of ready, short random stalls and longer stalls
    int stall_hold = 0;
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            stall_hold   = 0;
        end
        else if (stall_hold != 0)
        begin
            stall_hold--;
        end
        else
        begin
            case ($urandom_range(0, 3))
                0, 1:
                begin
                    rsp_if.ready <= 1'b1;
                    stall_hold   = $urandom_range(0, 20);
                end
                2:
                begin
                    rsp_if.ready <= 1'b0;
                    stall_hold   = $urandom_range(0, 3);
                end
                default:
                begin
                    rsp_if.ready <= 1'b0;
                    stall_hold   = $urandom_range(4, 12);
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic test_cleared_after_reset();
        send_cmd(CMD_READ, 6'd0,  6'd0,  6'd0,  1'b0);
        send_cmd(CMD_READ, 6'd63, 6'd63, 6'd63, 1'b1);
        send_cmd(CMD_READ, 6'd0,  6'd63, 6'd0,  1'b1);
        send_cmd(CMD_READ, 6'd63, 6'd0,  6'd63, 1'b0);
    endtask

    task automatic test_zero_radius();
        send_cmd(CMD_DRAW, 6'd10, 6'd10, 6'd0, 1'b1);
        send_cmd(CMD_READ, 6'd10, 6'd10, 6'd0, 1'b0);
        send_cmd(CMD_READ, 6'd10, 6'd11, 6'd0, 1'b0);
    endtask

    task automatic test_clipping();
        send_cmd(CMD_DRAW, 6'd0,  6'd0,  6'd63, 1'b1);
        send_cmd(CMD_DRAW, 6'd32, 6'd32, 6'd31, 1'b1);
        send_cmd(CMD_DRAW, 6'd32, 6'd32, 6'd32, 1'b1);
        send_cmd(CMD_DRAW, 6'd63, 6'd63, 6'd5,  1'b1);
        send_cmd(CMD_READ, 6'd0,  6'd63, 6'd0,  1'b0);
        send_cmd(CMD_READ, 6'd63, 6'd58, 6'd0,  1'b0);
    endtask

    task automatic test_set_and_clear();
        send_cmd(CMD_DRAW, 6'd20, 6'd40, 6'd10, 1'b1);
        wait_idle();
        // radius and pen carry junk on reads, they must not matter
        send_cmd(CMD_READ, 6'd30, 6'd40, 6'd63, 1'b1);
        send_cmd(CMD_READ, 6'd20, 6'd50, 6'd17, 1'b0);
        send_cmd(CMD_READ, 6'd10, 6'd40, 6'd42, 1'b1);
        send_cmd(CMD_DRAW, 6'd20, 6'd40, 6'd10, 1'b0);
        send_cmd(CMD_READ, 6'd30, 6'd40, 6'd0,  1'b0);
        send_cmd(CMD_READ, 6'd20, 6'd30, 6'd0,  1'b0);
    endtask

    task automatic test_random_mix();
        logic [IN_W-1:0] rad;
        logic [IN_W-1:0] r;
        logic [IN_W-1:0] c;
        int              pick;
        for (int n = 0; n < ITEM_COUNT; n++)
        begin
            if (n != 0 && n % 500 == 0)
                wait_idle();
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                // mostly small circles, a few large ones
                case ($urandom_range(0, 19))
                    0:       rad = IN_W'($urandom_range(41, 63));
                    1, 2:    rad = IN_W'($urandom_range(16, 40));
                    default: rad = IN_W'($urandom_range(0, 15));
                endcase
                send_cmd(CMD_DRAW, IN_W'($urandom), IN_W'($urandom), rad,
                         $urandom_range(0, 9) < 7);
            end
            else if (pick < 75)
            begin
                // land on or next to a point of the last circle
                case ($urandom_range(0, 3))
                    0:
                    begin
                        r = last_row + last_rad;
                        c = last_col;
                    end
                    1:
                    begin
                        r = last_row - last_rad;
                        c = last_col;
                    end
                    2:
                    begin
                        r = last_row;
                        c = last_col + last_rad;
                    end
                    default:
                    begin
                        r = last_row;
                        c = last_col - last_rad;
                    end
                endcase
                if ($urandom_range(0, 3) == 0)
                    c = c + 1'b1;
                send_cmd(CMD_READ, r, c, IN_W'($urandom), 1'($urandom));
            end
            else
            begin
                send_cmd(CMD_READ, IN_W'($urandom), IN_W'($urandom), IN_W'($urandom),
                         1'($urandom));
            end
        end
    endtask

    initial
    begin
        foreach (pix_mem[i, j])
            pix_mem[i][j] = 1'b0;
        rst_n         = 1'b0;
        req_if.valid  = 1'b0;
        req_if.cmd    = CMD_DRAW;
        req_if.row    = '0;
        req_if.col    = '0;
        req_if.radius = '0;
        req_if.pen    = 1'b0;
        rsp_if.ready  = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_cleared_after_reset();
        test_zero_radius();
        test_clipping();
        test_set_and_clear();
        test_random_mix();

        req_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_pix_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_cnt == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
